### design/obcr_pkg.sv
// Shared types, codes and constants of the oriented box cost rasterizer.
package obcr_pkg;

  localparam int DefGridCols = 64;
  localparam int DefGridRows = 64;

  localparam int InDataW  = 184;
  localparam int OutDataW = 24;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam int ProdW  = 54;
  localparam int WorldW = 48;
  localparam int LocW   = 64;
  localparam int CountW = 13;

  localparam logic [7:0]        NoInfo   = 8'hFF;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [CfgIdxW-1:0] CfgOriginX      = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOriginY      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCellSize     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCellsPerMeter = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PAINT = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    MS_ACHX, MS_ASHY, MS_ASHX, MS_ACHY,
    MS_CCS,  MS_SCS,
    MS_CBX,  MS_SBY,  MS_CBY,  MS_SBX,
    MS_HX0,  MS_LX0,  MS_HX1,  MS_LX1,
    MS_HY0,  MS_LY0,  MS_HY1,  MS_LY1
  } mul_step_e;

  localparam int NumSteps = 18;

  typedef enum logic [3:0] {
    DP_NOP, DP_CAPTURE, DP_CLR_STEP, DP_MUL, DP_EXT, DP_WORLD, DP_CELL,
    DP_INIT, DP_SEEK_COL, DP_SEEK_ROW, DP_MARK, DP_WALK_RD, DP_WALK_WR,
    DP_READ_RD, DP_LOAD_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    RK_ZERO, RK_PAINT, RK_OFF, RK_READ
  } res_kind_e;

  typedef enum logic [3:0] {
    S_RST_CLEAR, S_IDLE, S_CLEAR, S_MUL_A, S_EXT, S_WORLD, S_MUL_B, S_CELL,
    S_INIT, S_SEEK_COL, S_SEEK_ROW, S_MARK, S_WALK_RD, S_WALK_WR, S_READ_RD,
    S_FINISH
  } state_e;

  typedef struct packed {
    dp_op_e    op;
    mul_step_e mstep;
    res_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic off_map;
    logic col_seek_done;
    logic row_seek_done;
    logic col_last;
    logic row_last;
    logic clr_last;
    logic out_free;
  } dp_stat_t;

endpackage

### design/obcr_ctrl.sv
// Sequencing state machine of the oriented box cost rasterizer.
module obcr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic [1:0]          s_op_i,
  output logic                s_ready_o,
  input  obcr_pkg::dp_stat_t  stat_i,
  output obcr_pkg::dp_cmd_t   cmd_o
);
  import obcr_pkg::*;

  state_e    state_q, state_d;
  mul_step_e mstep_q, mstep_d;
  res_kind_e kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_CLEAR;
      mstep_q <= MS_ACHX;
      kind_q  <= RK_ZERO;
    end else begin
      state_q <= state_d;
      mstep_q <= mstep_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mstep_d = mstep_q;
    kind_d  = kind_q;
    unique case (state_q)
      S_RST_CLEAR: if (stat_i.clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (s_valid_i) begin
          unique case (s_op_i)
            OP_CLEAR: state_d = S_CLEAR;
            OP_PAINT: begin
              state_d = S_MUL_A;
              mstep_d = MS_ACHX;
            end
            OP_READ: begin
              state_d = S_READ_RD;
              kind_d  = RK_READ;
            end
            default: begin
              state_d = S_FINISH;
              kind_d  = RK_ZERO;
            end
          endcase
        end
      end
      S_CLEAR: begin
        if (stat_i.clr_last) begin
          state_d = S_FINISH;
          kind_d  = RK_ZERO;
        end
      end
      S_MUL_A: begin
        mstep_d = mul_step_e'(mstep_q + 5'd1);
        if (mstep_q == MS_SBX) state_d = S_EXT;
      end
      S_EXT: state_d = S_WORLD;
      S_WORLD: begin
        state_d = S_MUL_B;
        mstep_d = MS_HX0;
      end
      S_MUL_B: begin
        if (stat_i.off_map) begin
          state_d = S_FINISH;
          kind_d  = RK_OFF;
        end else begin
          mstep_d = mul_step_e'(mstep_q + 5'd1);
          if (mstep_q == MS_LY1) state_d = S_CELL;
        end
      end
      S_CELL:     state_d = S_INIT;
      S_INIT:     state_d = S_SEEK_COL;
      S_SEEK_COL: if (stat_i.col_seek_done) state_d = S_SEEK_ROW;
      S_SEEK_ROW: if (stat_i.row_seek_done) state_d = S_MARK;
      S_MARK:     state_d = S_WALK_RD;
      S_WALK_RD:  state_d = S_WALK_WR;
      S_WALK_WR: begin
        if (stat_i.col_last && stat_i.row_last) begin
          state_d = S_FINISH;
          kind_d  = RK_PAINT;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_READ_RD: state_d = S_FINISH;
      S_FINISH:  if (stat_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o   = 1'b0;
    cmd_o.op    = DP_NOP;
    cmd_o.mstep = mstep_q;
    cmd_o.kind  = kind_q;
    unique case (state_q)
      S_RST_CLEAR, S_CLEAR: cmd_o.op = DP_CLR_STEP;
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o.op = DP_CAPTURE;
      end
      S_MUL_A:    cmd_o.op = DP_MUL;
      S_EXT:      cmd_o.op = DP_EXT;
      S_WORLD:    cmd_o.op = DP_WORLD;
      S_MUL_B:    if (!stat_i.off_map) cmd_o.op = DP_MUL;
      S_CELL:     cmd_o.op = DP_CELL;
      S_INIT:     cmd_o.op = DP_INIT;
      S_SEEK_COL: if (!stat_i.col_seek_done) cmd_o.op = DP_SEEK_COL;
      S_SEEK_ROW: if (!stat_i.row_seek_done) cmd_o.op = DP_SEEK_ROW;
      S_MARK:     cmd_o.op = DP_MARK;
      S_WALK_RD:  cmd_o.op = DP_WALK_RD;
      S_WALK_WR:  cmd_o.op = DP_WALK_WR;
      S_READ_RD:  cmd_o.op = DP_READ_RD;
      S_FINISH:   if (stat_i.out_free) cmd_o.op = DP_LOAD_OUT;
      default:    cmd_o.op = DP_NOP;
    endcase
  end

endmodule

### design/obcr_datapath.sv
// Datapath of the oriented box cost rasterizer: registers, shared multiplier, walker, grid.
module obcr_datapath #(
  parameter int GRID_COLS = obcr_pkg::DefGridCols,
  parameter int GRID_ROWS = obcr_pkg::DefGridRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [obcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [obcr_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [obcr_pkg::InDataW-1:0]  s_data_i,
  input  obcr_pkg::dp_cmd_t             cmd_i,
  output obcr_pkg::dp_stat_t            stat_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [obcr_pkg::OutDataW-1:0] m_data_o
);
  import obcr_pkg::*;

  localparam int Depth = GRID_COLS * GRID_ROWS;
  localparam int AddrW = $clog2(Depth);
  localparam int ColW  = $clog2(GRID_COLS);
  localparam int RowW  = $clog2(GRID_ROWS);
  localparam int IdxW  = (ColW > RowW) ? ColW : RowW;

  // Configuration registers.
  logic signed [31:0] ox_q, oy_q;
  logic        [30:0] cs_q, cpm_q;
  logic signed [WorldW-1:0] span_x_q, span_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= '0;
      oy_q  <= '0;
      cs_q  <= 31'd3277;
      cpm_q <= 31'd1310720;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOriginX:       ox_q  <= cfg_wdata_i;
        CfgOriginY:       oy_q  <= cfg_wdata_i;
        CfgCellSize:      cs_q  <= cfg_wdata_i[30:0];
        CfgCellsPerMeter: cpm_q <= cfg_wdata_i[30:0];
        default:          ox_q  <= ox_q;
      endcase
    end
  end

  // Map extent in world units, refreshed from the cell size every cycle.
  always_ff @(posedge clk_i) begin
    span_x_q <= $signed(WorldW'(cs_q) * WorldW'(GRID_COLS));
    span_y_q <= $signed(WorldW'(cs_q) * WorldW'(GRID_ROWS));
  end

  // Captured item.
  logic signed [31:0] cx_q, cy_q;
  logic signed [15:0] c_q, s_q;
  logic        [30:0] hx_q, hy_q;
  logic        [7:0]  cost_q;
  logic        [5:0]  rc_q, rr_q;
  logic signed [34:0] bx_q, by_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CAPTURE) begin
      cx_q   <= s_data_i[31:0];
      cy_q   <= s_data_i[63:32];
      c_q    <= s_data_i[79:64];
      s_q    <= s_data_i[95:80];
      hx_q   <= s_data_i[126:96];
      hy_q   <= s_data_i[157:127];
      cost_q <= s_data_i[165:158];
      rc_q   <= s_data_i[171:166];
      rr_q   <= s_data_i[177:172];
      // Offsets of the grid corner cell center from the box center.
      bx_q <= 35'(ox_q) + 35'(cs_q[30:1]) - 35'($signed(s_data_i[31:0]));
      by_q <= 35'(oy_q) + 35'(cs_q[30:1]) - 35'($signed(s_data_i[63:32]));
    end
  end

  logic [16:0] ac, as;
  assign ac = c_q[15] ? (17'd0 - 17'(c_q)) : 17'(c_q);
  assign as = s_q[15] ? (17'd0 - 17'(s_q)) : 17'(s_q);

  // Shared multiplier; each step lands in its own product register.
  logic signed [34:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [66:0] mul_p;
  logic signed [ProdW-1:0] p_q [NumSteps];
  logic [19:0] hi_q [4];
  logic [15:0] lo_q [4];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mstep)
      MS_ACHX: begin mul_a = $signed(35'(hx_q)); mul_b = $signed(32'(ac)); end
      MS_ASHY: begin mul_a = $signed(35'(hy_q)); mul_b = $signed(32'(as)); end
      MS_ASHX: begin mul_a = $signed(35'(hx_q)); mul_b = $signed(32'(as)); end
      MS_ACHY: begin mul_a = $signed(35'(hy_q)); mul_b = $signed(32'(ac)); end
      MS_CCS:  begin mul_a = $signed(35'(cs_q)); mul_b = 32'(c_q); end
      MS_SCS:  begin mul_a = $signed(35'(cs_q)); mul_b = 32'(s_q); end
      MS_CBX:  begin mul_a = bx_q; mul_b = 32'(c_q); end
      MS_SBY:  begin mul_a = by_q; mul_b = 32'(s_q); end
      MS_CBY:  begin mul_a = by_q; mul_b = 32'(c_q); end
      MS_SBX:  begin mul_a = bx_q; mul_b = 32'(s_q); end
      MS_HX0:  begin mul_a = $signed(35'(hi_q[0])); mul_b = $signed(32'(cpm_q)); end
      MS_LX0:  begin mul_a = $signed(35'(lo_q[0])); mul_b = $signed(32'(cpm_q)); end
      MS_HX1:  begin mul_a = $signed(35'(hi_q[1])); mul_b = $signed(32'(cpm_q)); end
      MS_LX1:  begin mul_a = $signed(35'(lo_q[1])); mul_b = $signed(32'(cpm_q)); end
      MS_HY0:  begin mul_a = $signed(35'(hi_q[2])); mul_b = $signed(32'(cpm_q)); end
      MS_LY0:  begin mul_a = $signed(35'(lo_q[2])); mul_b = $signed(32'(cpm_q)); end
      MS_HY1:  begin mul_a = $signed(35'(hi_q[3])); mul_b = $signed(32'(cpm_q)); end
      MS_LY1:  begin mul_a = $signed(35'(lo_q[3])); mul_b = $signed(32'(cpm_q)); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_MUL) p_q[cmd_i.mstep] <= $signed(mul_p[ProdW-1:0]);
  end

  // Extents and cover limits.
  logic signed [WorldW-1:0] ext_x_q, ext_y_q;
  logic        [46:0]       lim_x_q, lim_y_q;
  logic signed [ProdW-1:0]  ext_sx, ext_sy;

  assign ext_sx = (p_q[MS_ACHX] + p_q[MS_ASHY]) >>> 14;
  assign ext_sy = (p_q[MS_ASHX] + p_q[MS_ACHY]) >>> 14;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_EXT) begin
      ext_x_q <= WorldW'(ext_sx);
      ext_y_q <= WorldW'(ext_sy);
      lim_x_q <= {33'(hx_q) + 33'(cs_q[30:1]), 14'b0};
      lim_y_q <= {33'(hy_q) + 33'(cs_q[30:1]), 14'b0};
    end
  end

  // Bounding box edges against the map: order is low x, high x, low y, high y.
  logic signed [WorldW-1:0] wv [4];
  logic signed [WorldW-1:0] orgv [4];
  logic signed [WorldW-1:0] spanv [4];
  logic signed [WorldW-1:0] diffv [4];
  logic [3:0] below_d, over_d, below_q, over_q;
  logic       off_d, off_q;

  always_comb begin
    wv[0]    = WorldW'(cx_q) - ext_x_q;
    wv[1]    = WorldW'(cx_q) + ext_x_q;
    wv[2]    = WorldW'(cy_q) - ext_y_q;
    wv[3]    = WorldW'(cy_q) + ext_y_q;
    orgv[0]  = WorldW'(ox_q);
    orgv[1]  = WorldW'(ox_q);
    orgv[2]  = WorldW'(oy_q);
    orgv[3]  = WorldW'(oy_q);
    spanv[0] = span_x_q;
    spanv[1] = span_x_q;
    spanv[2] = span_y_q;
    spanv[3] = span_y_q;
    for (int i = 0; i < 4; i++) begin
      diffv[i]   = wv[i] - orgv[i];
      below_d[i] = wv[i] < orgv[i];
      over_d[i]  = diffv[i] >= spanv[i];
    end
    off_d = below_d[1] || below_d[3] ||
            (wv[0] > orgv[0] + spanv[0]) || (wv[2] > orgv[2] + spanv[2]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_WORLD) begin
      below_q <= below_d;
      over_q  <= over_d;
      off_q   <= off_d;
      for (int i = 0; i < 4; i++) begin
        hi_q[i] <= diffv[i][35:16];
        lo_q[i] <= diffv[i][15:0];
      end
    end
  end

  // World to cell conversion from the fixed-point reciprocal products.
  logic [ProdW:0]  qsum [4];
  logic [ProdW:0]  qv [4];
  logic [ProdW:0]  nm1 [4];
  logic [IdxW-1:0] cellv [4];
  logic [ColW-1:0] c0_q, c1_q, col_q;
  logic [RowW-1:0] r0_q, r1_q, row_q;

  always_comb begin
    nm1[0] = (ProdW+1)'(GRID_COLS - 1);
    nm1[1] = (ProdW+1)'(GRID_COLS - 1);
    nm1[2] = (ProdW+1)'(GRID_ROWS - 1);
    nm1[3] = (ProdW+1)'(GRID_ROWS - 1);
    for (int i = 0; i < 4; i++) begin
      qsum[i] = (ProdW+1)'(p_q[MS_HX0 + 2*i]) + ((ProdW+1)'(p_q[MS_LX0 + 2*i]) >> 16);
      qv[i]   = qsum[i] >> 16;
      if (below_q[i]) begin
        cellv[i] = '0;
      end else if (over_q[i] || (qv[i] > nm1[i])) begin
        cellv[i] = nm1[i][IdxW-1:0];
      end else begin
        cellv[i] = qv[i][IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CELL) begin
      c0_q <= cellv[0][ColW-1:0];
      c1_q <= cellv[1][ColW-1:0];
      r0_q <= cellv[2][RowW-1:0];
      r1_q <= cellv[3][RowW-1:0];
    end
  end

  // Walker: box coordinates of the current cell are stepped, never multiplied.
  logic signed [LocW-1:0] lx_q, ly_q, lxr_q, lyr_q;
  logic signed [LocW-1:0] ccs, scs;
  logic [LocW-1:0] abs_lx, abs_ly;
  logic cover_q;
  logic [CountW-1:0] count_q;
  logic [7:0] rdata_q;
  logic [7:0] new_cost;

  assign ccs    = LocW'(p_q[MS_CCS]);
  assign scs    = LocW'(p_q[MS_SCS]);
  assign abs_lx = lx_q[LocW-1] ? LocW'(-lx_q) : LocW'(lx_q);
  assign abs_ly = ly_q[LocW-1] ? LocW'(-ly_q) : LocW'(ly_q);
  assign new_cost = (rdata_q == NoInfo) ? cost_q :
                    ((rdata_q > cost_q) ? rdata_q : cost_q);

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_INIT: begin
        lx_q  <= LocW'(p_q[MS_CBX]) + LocW'(p_q[MS_SBY]);
        ly_q  <= LocW'(p_q[MS_CBY]) - LocW'(p_q[MS_SBX]);
        col_q <= '0;
        row_q <= '0;
      end
      DP_SEEK_COL: begin
        lx_q  <= lx_q + ccs;
        ly_q  <= ly_q - scs;
        col_q <= col_q + 1'b1;
      end
      DP_SEEK_ROW: begin
        lx_q  <= lx_q + scs;
        ly_q  <= ly_q + ccs;
        row_q <= row_q + 1'b1;
      end
      DP_MARK: begin
        lxr_q <= lx_q;
        lyr_q <= ly_q;
      end
      DP_WALK_RD: begin
        cover_q <= (abs_lx <= LocW'(lim_x_q)) && (abs_ly <= LocW'(lim_y_q));
      end
      DP_WALK_WR: begin
        if (col_q == c1_q) begin
          col_q <= c0_q;
          if (row_q != r1_q) begin
            row_q <= row_q + 1'b1;
            lxr_q <= lxr_q + scs;
            lyr_q <= lyr_q + ccs;
            lx_q  <= lxr_q + scs;
            ly_q  <= lyr_q + ccs;
          end
        end else begin
          col_q <= col_q + 1'b1;
          lx_q  <= lx_q + ccs;
          ly_q  <= ly_q - scs;
        end
      end
      default: lx_q <= lx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_CAPTURE) begin
      count_q <= '0;
    end else if ((cmd_i.op == DP_WALK_WR) && cover_q && (count_q != CountMax)) begin
      count_q <= count_q + 1'b1;
    end
  end

  // Cost grid memory with a sweep address for clearing.
  logic [7:0]       grid_mem [Depth];
  logic [AddrW-1:0] clr_addr_q;
  logic [31:0]      walk_lin, read_lin;
  logic [AddrW-1:0] walk_addr, read_addr, rd_addr, wr_addr;
  logic [7:0]       wr_data;
  logic             wr_en, rd_en, read_in_range;

  assign walk_lin  = 32'(row_q) * 32'(GRID_COLS) + 32'(col_q);
  assign read_lin  = 32'(rr_q) * 32'(GRID_COLS) + 32'(rc_q);
  assign walk_addr = walk_lin[AddrW-1:0];
  assign read_addr = read_lin[AddrW-1:0];
  assign read_in_range = (32'(rc_q) < 32'(GRID_COLS)) && (32'(rr_q) < 32'(GRID_ROWS));

  assign rd_en   = (cmd_i.op == DP_WALK_RD) || (cmd_i.op == DP_READ_RD);
  assign rd_addr = (cmd_i.op == DP_READ_RD) ? read_addr : walk_addr;
  assign wr_en   = (cmd_i.op == DP_CLR_STEP) || ((cmd_i.op == DP_WALK_WR) && cover_q);
  assign wr_addr = (cmd_i.op == DP_CLR_STEP) ? clr_addr_q : walk_addr;
  assign wr_data = (cmd_i.op == DP_CLR_STEP) ? NoInfo : new_cost;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.op == DP_CLR_STEP) begin
      clr_addr_q <= stat_o.clr_last ? '0 : clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= grid_mem[rd_addr];
  end

  // Result register.
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic [7:0]          res_cell;
  logic [CountW-1:0]   res_count;
  logic                res_off;

  assign res_cell  = (cmd_i.kind == RK_READ) ? (read_in_range ? rdata_q : NoInfo) : 8'd0;
  assign res_count = (cmd_i.kind == RK_PAINT) ? count_q : '0;
  assign res_off   = (cmd_i.kind == RK_OFF);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_LOAD_OUT) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD_OUT) m_data_q <= {2'b00, res_off, res_count, res_cell};
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;

  assign stat_o.off_map       = off_q;
  assign stat_o.col_seek_done = (col_q == c0_q);
  assign stat_o.row_seek_done = (row_q == r0_q);
  assign stat_o.col_last      = (col_q == c1_q);
  assign stat_o.row_last      = (row_q == r1_q);
  assign stat_o.clr_last      = (clr_addr_q == AddrW'(Depth - 1));
  assign stat_o.out_free      = !m_valid_q || m_ready_i;

endmodule

### design/oriented_box_cost_rasterizer_unit.sv
// Top level of the oriented box cost rasterizer: controller, datapath and ports.
//
// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/tready         one command word per operation
// m_axis    out        m_axis_tvalid/tready         one result word per command
// cfg       in         cfg_we_i, no back pressure   origin, cell size, reciprocal
//
// A read takes one grid read; a clear sweeps every grid address.
// A paint is set up by eighteen shared multiplier steps, then a seek walks
// from the grid corner to the box corner, and each cell of the bounding box
// costs a read and a write on the grid. A paint that misses the grid ends
// once the box is found off the map, before any cell is walked.
// After reset a clearing pass over all GRID_COLS*GRID_ROWS cells fills the
// grid with 255; no command word is taken during it, configuration writes are.
// A finished result waits in the output register; the next command word is taken
// while it waits, and the block stalls only when a second result is ready.
module oriented_box_cost_rasterizer_unit #(
  parameter int GRID_COLS = obcr_pkg::DefGridCols,
  parameter int GRID_ROWS = obcr_pkg::DefGridRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [obcr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [obcr_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Command stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata from bit 0: box_x 32, box_y 32, cos_yaw 16, sin_yaw 16, half_x 31,
  // half_y 31, paint_cost 8, read_col 6, read_row 6, zero fill 6.
  input  logic [obcr_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: op 2.
  input  logic [1:0]                    s_axis_tuser,
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata from bit 0: cell_cost 8, cells_painted 13, off_map 1, zero fill 2.
  output logic [obcr_pkg::OutDataW-1:0] m_axis_tdata
);
  import obcr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller sequences every operation; the datapath holds the data registers and the grid.
  obcr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  obcr_datapath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_data_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

  // One operation at a time: a taken word closes the input for the next cycle.
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command word taken while an operation is in flight");

  // A box off the map paints nothing.
  a_off_no_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[20:8] == 13'd0)
    else $error("off map result carries a painted count");

  // A read result carries only the cell cost.
  a_read_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |-> m_axis_tdata[21:8] == 14'd0)
    else $error("read result mixed with paint fields");

endmodule
